// File: hw/rtl/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg
// Shared widths, codes and defaults for the point-in-convex-polygon block.
// ----------------------------------------------------------------------------
package pic_pkg;

  // default depth of the vertex store
  localparam int MAX_VERTICES_DEF = 16;

  // field widths
  localparam int COORD_W = 16;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  // derived arithmetic widths: differences, products, cross product
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // register word index (paddr[2])
  localparam logic REG_VERTEX_COUNT = 1'b0;

endpackage

// File: hw/rtl/point_in_convex_polygon_top.sv
// ----------------------------------------------------------------------------
// point_in_convex_polygon_top
// Cross-product sign test of a point against a convex polygon held in a
// vertex memory, with an APB-style register port for the vertex count.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a rising edge with start high and busy low. kind
//   selects a vertex load (vertex_index, coord_x, coord_y written to the
//   store, no result) or a point query (coord_x, coord_y tested).
//   A query gives one result: done pulses for one cycle with inside_res,
//   high for points inside or on the boundary. The receiver cannot stall;
//   the result is gone after that cycle.
//   Timing: a load leaves busy low. A query with a count of zero or
//   one answers in the cycle after it is taken. Otherwise a query reads
//   one vertex per cycle from the single-port vertex memory: the n vertices
//   in use (n capped at MAX_VERTICES), then one wrap-around edge, then the
//   difference, multiply and compare stages. busy is high for the whole walk.
//   Register 0 (byte address 0) holds vertex_count, to be written only while idle;
//   the block does not enforce it. Reset clears the count and the control state;
//   the vertex memory holds whatever it held and must be loaded before a query.
// ----------------------------------------------------------------------------
module point_in_convex_polygon_top #(
  parameter int MAX_VERTICES = pic_pkg::MAX_VERTICES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // item channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                kind,
  input  logic [pic_pkg::INDEX_W-1:0]         vertex_index,
  input  logic signed [pic_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [pic_pkg::COORD_W-1:0]  coord_y,
  // result channel
  output logic                                done,
  output logic                                inside_res,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pic_pkg::APB_AW-1:0]          paddr,
  input  logic [pic_pkg::APB_DW-1:0]          pwdata,
  output logic [pic_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);
  import pic_pkg::*;

  localparam int AddrW = $clog2(MAX_VERTICES);
  localparam int CntW  = $clog2(MAX_VERTICES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_t;

  state_t state;

  // register port
  logic [COUNT_W-1:0] vertex_count;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_wr && paddr[2] == REG_VERTEX_COUNT) begin
      vertex_count <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_VERTEX_COUNT) begin
      prdata = APB_DW'(vertex_count);
    end
  end

  // item acceptance and vertex count in use
  logic            accept;
  logic            load_ok;
  logic [CntW-1:0] n_use;
  logic [CntW-1:0] n_m1;

  assign accept  = start && !busy;
  assign load_ok = accept && kind == KIND_LOAD && int'(vertex_index) < MAX_VERTICES;

  always_comb begin
    if (int'(vertex_count) > MAX_VERTICES) begin
      n_use = CntW'(MAX_VERTICES);
    end else begin
      n_use = CntW'(vertex_count);
    end
    n_m1 = n_use - CntW'(1);
  end

  // query point and walk bookkeeping
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic [AddrW-1:0]          last_idx;
  logic [AddrW-1:0]          idx;

  always_ff @(posedge clk) begin
    if (accept && kind == KIND_QUERY) begin
      px       <= coord_x;
      py       <= coord_y;
      last_idx <= n_m1[AddrW-1:0];
    end
  end

  // vertex memory: x in the upper half, y in the lower half
  logic [2*COORD_W-1:0]      vmem [MAX_VERTICES];
  logic                      rd_en;
  logic signed [COORD_W-1:0] rd_x;
  logic signed [COORD_W-1:0] rd_y;
  logic                      rd_vld;
  logic                      rd_first;
  logic                      rd_last;

  assign rd_en = (state == ST_WALK);

  always_ff @(posedge clk) begin
    if (load_ok) begin
      vmem[AddrW'(vertex_index)] <= {coord_x, coord_y};
    end
    if (rd_en) begin
      {rd_x, rd_y} <= vmem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      rd_first <= 1'b0;
      rd_last  <= 1'b0;
    end else begin
      rd_vld   <= rd_en;
      rd_first <= rd_en && idx == '0;
      rd_last  <= rd_en && idx == last_idx;
    end
  end

  // edge former: previous vertex to current, then last back to first
  logic signed [COORD_W-1:0] first_x;
  logic signed [COORD_W-1:0] first_y;
  logic signed [COORD_W-1:0] prev_x;
  logic signed [COORD_W-1:0] prev_y;
  logic                      wrap_pend;
  logic                      edge_go;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;

  assign edge_go = (rd_vld && !rd_first) || wrap_pend;
  assign end_x   = wrap_pend ? first_x : rd_x;
  assign end_y   = wrap_pend ? first_y : rd_y;

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prev_x <= rd_x;
      prev_y <= rd_y;
    end
    if (rd_vld && rd_first) begin
      first_x <= rd_x;
      first_y <= rd_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_pend <= 1'b0;
    end else begin
      wrap_pend <= rd_vld && rd_last;
    end
  end

  // difference stage
  logic signed [DIFF_W-1:0] d_px;
  logic signed [DIFF_W-1:0] d_ey;
  logic signed [DIFF_W-1:0] d_py;
  logic signed [DIFF_W-1:0] d_ex;
  logic                     d_vld;
  logic                     d_last;

  always_ff @(posedge clk) begin
    if (edge_go) begin
      d_px <= {px[COORD_W-1], px} - {prev_x[COORD_W-1], prev_x};
      d_ey <= {end_y[COORD_W-1], end_y} - {prev_y[COORD_W-1], prev_y};
      d_py <= {py[COORD_W-1], py} - {prev_y[COORD_W-1], prev_y};
      d_ex <= {end_x[COORD_W-1], end_x} - {prev_x[COORD_W-1], prev_x};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld  <= 1'b0;
      d_last <= 1'b0;
    end else begin
      d_vld  <= edge_go;
      d_last <= wrap_pend;
    end
  end

  // multiply stage
  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_b;
  logic                     m_vld;
  logic                     m_last;

  always_ff @(posedge clk) begin
    if (d_vld) begin
      prod_a <= d_px * d_ey;
      prod_b <= d_py * d_ex;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld  <= 1'b0;
      m_last <= 1'b0;
    end else begin
      m_vld  <= d_vld;
      m_last <= d_last;
    end
  end

  // cross product sign and outside flag over the edges
  logic signed [CROSS_W-1:0] cross_val;
  logic                      right_of;
  logic                      outside;

  assign cross_val = {prod_a[PROD_W-1], prod_a} - {prod_b[PROD_W-1], prod_b};
  assign right_of  = !cross_val[CROSS_W-1] && cross_val != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      outside <= 1'b0;
    end else if (m_vld) begin
      outside <= m_last ? 1'b0 : (outside || right_of);
    end
  end

  // control: state, walk address, busy and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      busy       <= 1'b0;
      done       <= 1'b0;
      inside_res <= 1'b0;
      idx        <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && kind == KIND_QUERY) begin
            idx <= '0;
            if (n_use <= CntW'(1)) begin
              // no edge or one degenerate edge: always inside
              done       <= 1'b1;
              inside_res <= 1'b1;
            end else begin
              busy  <= 1'b1;
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          idx <= idx + AddrW'(1);
          if (idx == last_idx) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (m_vld && m_last) begin
            done       <= 1'b1;
            inside_res <= !(outside || right_of);
            busy       <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the point-in-convex-polygon block. Vertex loads and
// point queries go in through the start/busy channel. The vertex count is set
// and read back over the register port. Each query's inside/outside answer is
// predicted from a shadow vertex store. Directed cases cover counts of zero,
// one and two, and points on the boundary at the coordinate extremes. A
// saturated count is also covered. Random rounds then load convex polygons
// and fire queries near them, on them and anywhere, with random gaps.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pic_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int MAX_V = MAX_VERTICES_DEF;
  localparam int ITEM_TARGET = 1800;
  // longest query walk plus margin
  localparam int SETTLE_CYCLES = MAX_V + 12;
  localparam longint LIMIT_NS = 5_000_000;
  localparam int REPORT_CAP = 100;
  localparam logic [APB_AW-1:0] VERTEX_COUNT_ADDR = {REG_VERTEX_COUNT, 2'b00};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic kind;
  logic [INDEX_W-1:0] vertex_index;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic done;
  logic inside_res;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  // shadow of the block state
  logic signed [COORD_W-1:0] vx_store [MAX_V];
  logic signed [COORD_W-1:0] vy_store [MAX_V];
  logic [COUNT_W-1:0] vertex_count_shadow = '0;

  bit expected_inside_q [$];
  bit expected_now;
  int mismatch_count = 0;
  int items_sent = 0;

  point_in_convex_polygon_top #(
    .MAX_VERTICES(MAX_V)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .vertex_index(vertex_index),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .done(done),
    .inside_res(inside_res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // run limit
  initial begin
    #(LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    // further mismatches are counted only
    if (mismatch_count <= REPORT_CAP) begin
      $display("ERROR %0t ns: %s", $time, msg);
    end
  endtask

  // cross-product sign test over the stored polygon
  function automatic bit predict_inside(input logic signed [COORD_W-1:0] px,
                                        input logic signed [COORD_W-1:0] py);
    int n;
    int j;
    longint cprod;
    n = (vertex_count_shadow > MAX_V) ? MAX_V : int'(vertex_count_shadow);
    for (int i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      cprod = (longint'(px) - longint'(vx_store[i])) *
              (longint'(vy_store[j]) - longint'(vy_store[i])) -
              (longint'(py) - longint'(vy_store[i])) *
              (longint'(vx_store[j]) - longint'(vx_store[i]));
      if (cprod > 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp16(input int v);
    if (v > int'(COORD_MAX)) return COORD_MAX;
    if (v < int'(COORD_MIN)) return COORD_MIN;
    return COORD_W'(v);
  endfunction

  function automatic logic signed [COORD_W-1:0] rand16();
    return COORD_W'($urandom);
  endfunction

  // check each result against the oldest expected answer
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_inside_q.size() == 0) begin
        report_mismatch($sformatf("result with no query pending, inside_res=%0b",
                                  inside_res));
      end else begin
        expected_now = expected_inside_q.pop_front();
        if (inside_res !== expected_now) begin
          report_mismatch($sformatf("inside_res=%0b, expected %0b",
                                    inside_res, expected_now));
        end
      end
    end
  end

  // drive one item after a gap, hold it until taken, then update the shadow
  task automatic send_item(input logic k, input logic [INDEX_W-1:0] idx,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    kind <= k;
    vertex_index <= idx;
    coord_x <= x;
    coord_y <= y;
    do @(posedge clk); while (busy);
    if (k == KIND_LOAD) begin
      vx_store[idx] = x;
      vy_store[idx] = y;
    end else begin
      expected_inside_q.push_back(predict_inside(x, y));
    end
    items_sent++;
  endtask

  // lower start and hold off until every pending answer is in
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (expected_inside_q.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_vertex_count_readback();
    logic [APB_DW-1:0] rd;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= VERTEX_COUNT_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[COUNT_W-1:0] !== vertex_count_shadow) begin
      report_mismatch($sformatf("vertex_count reads %0d, expected %0d",
                                rd[COUNT_W-1:0], vertex_count_shadow));
    end
  endtask

  // count changes only once the block is idle, loads included
  task automatic set_vertex_count(input logic [COUNT_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(VERTEX_COUNT_ADDR, APB_DW'(value));
    vertex_count_shadow = value;
    check_vertex_count_readback();
  endtask

  // load a convex n-gon, set the count, then query around it
  task automatic run_polygon_round(input int n, input logic [COUNT_W-1:0] count_value,
                                   input bit steady);
    int cx;
    int cy;
    int rad;
    int span;
    int q_total;
    int sel;
    int k;
    int gap;
    real phase;
    real ang;
    int px [MAX_V];
    int py [MAX_V];
    bit clockwise;
    bit reversed;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    cx = int'($urandom_range(0, 24000)) - 12000;
    cy = int'($urandom_range(0, 24000)) - 12000;
    rad = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 64))
                                      : int'($urandom_range(64, 20000));
    clockwise = ($urandom_range(0, 7) == 0);
    phase = $urandom_range(0, 999) / 1000.0 * 6.283185307;
    // points on a circle in angular order, jittered less than one step
    for (int i = 0; i < n; i++) begin
      ang = phase + 6.283185307 * (i + $urandom_range(0, 400) / 1000.0) / n;
      if (clockwise) ang = -ang;
      px[i] = cx + $rtoi(rad * $cos(ang));
      py[i] = cy + $rtoi(rad * $sin(ang));
    end
    reversed = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      k = reversed ? n - 1 - i : i;
      send_item(KIND_LOAD, INDEX_W'(k), clamp16(px[k]), clamp16(py[k]),
                steady ? 0 : $urandom_range(0, 5));
    end
    // noise in a slot the walk does not reach
    if (n < MAX_V && $urandom_range(0, 1)) begin
      send_item(KIND_LOAD, INDEX_W'($urandom_range(n, MAX_V - 1)), rand16(), rand16(),
                steady ? 0 : $urandom_range(0, 5));
    end
    set_vertex_count(count_value);
    q_total = $urandom_range(15, 35);
    span = rad + rad / 4 + 2;
    for (int q = 0; q < q_total; q++) begin
      gap = steady ? 0 : $urandom_range(0, 5);
      sel = $urandom_range(0, 19);
      k = $urandom_range(0, n - 1);
      if (sel < 8) begin
        // near the polygon, either side of its edges
        qx = clamp16(cx - span + int'($urandom_range(0, 2 * span)));
        qy = clamp16(cy - span + int'($urandom_range(0, 2 * span)));
      end else if (sel < 11) begin
        qx = clamp16(px[k]);
        qy = clamp16(py[k]);
      end else if (sel < 14) begin
        // edge midpoint, on or next to the boundary
        qx = clamp16((px[k] + px[(k + 1) % n]) >>> 1);
        qy = clamp16((py[k] + py[(k + 1) % n]) >>> 1);
      end else begin
        qx = rand16();
        qy = rand16();
      end
      if ($urandom_range(0, 29) == 0) wait_drained();
      // a vertex moved between queries
      if ($urandom_range(0, 24) == 0) begin
        send_item(KIND_LOAD, INDEX_W'($urandom), qy, qx, gap);
      end
      send_item(KIND_QUERY, INDEX_W'($urandom), qx, qy, gap);
    end
  endtask

  task automatic test_empty_polygon();
    check_vertex_count_readback();
    send_item(KIND_QUERY, '0, COORD_MIN, COORD_MIN, 0);
    set_vertex_count('0);
    send_item(KIND_QUERY, '1, COORD_MAX, COORD_MAX, 0);
  endtask

  task automatic test_single_vertex();
    send_item(KIND_LOAD, '0, COORD_MIN, COORD_MIN, 0);
    set_vertex_count(COUNT_W'(1));
    send_item(KIND_QUERY, '0, COORD_MAX, COORD_MAX, 2);
    send_item(KIND_QUERY, '1, '0, '0, 0);
  endtask

  // full-range square, then the degenerate segment and a triangle from it
  task automatic test_extreme_square();
    send_item(KIND_LOAD, INDEX_W'(1), COORD_MAX, COORD_MIN, 0);
    send_item(KIND_LOAD, INDEX_W'(2), COORD_MAX, COORD_MAX, 1);
    send_item(KIND_LOAD, INDEX_W'(3), COORD_MIN, COORD_MAX, 0);
    set_vertex_count(COUNT_W'(4));
    send_item(KIND_QUERY, '0, '0, '0, 0);
    send_item(KIND_QUERY, '0, COORD_MAX, COORD_MAX, 0);
    send_item(KIND_QUERY, '0, '0, COORD_MIN, 3);
    send_item(KIND_QUERY, '0, COORD_MIN, '0, 0);
    set_vertex_count(COUNT_W'(2));
    send_item(KIND_QUERY, '0, '0, '0, 0);
    send_item(KIND_QUERY, '0, '0, COORD_MIN, 0);
    set_vertex_count(COUNT_W'(3));
    send_item(KIND_QUERY, '0, COORD_MIN, COORD_MAX, 0);
    send_item(KIND_QUERY, '0, COORD_MAX, COORD_MIN, 1);
  endtask

  // count beyond the store depth walks the whole store
  task automatic test_count_saturation();
    run_polygon_round(MAX_V, '1, 1'b0);
  endtask

  task automatic test_random_polygons();
    int n;
    bit steady;
    logic [COUNT_W-1:0] cnt;
    while (items_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // counts of zero, one and two
        set_vertex_count(COUNT_W'($urandom_range(0, 2)));
        repeat ($urandom_range(5, 12)) begin
          if ($urandom_range(0, 1)) begin
            n = $urandom_range(0, 1);
            send_item(KIND_QUERY, INDEX_W'($urandom), vx_store[n], vy_store[n],
                      steady ? 0 : $urandom_range(0, 5));
          end else begin
            send_item(KIND_QUERY, INDEX_W'($urandom), rand16(), rand16(),
                      steady ? 0 : $urandom_range(0, 5));
          end
        end
      end else begin
        n = ($urandom_range(0, 4) == 0) ? MAX_V : $urandom_range(3, MAX_V);
        cnt = COUNT_W'(n);
        if (n == MAX_V && $urandom_range(0, 2) == 0) begin
          cnt = COUNT_W'($urandom_range(MAX_V + 1, (1 << COUNT_W) - 1));
        end
        run_polygon_round(n, cnt, steady);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_LOAD;
    vertex_index = '0;
    coord_x = '0;
    coord_y = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_polygon();
    test_single_vertex();
    test_extreme_square();
    test_count_saturation();
    test_random_polygons();

    // drain, then give stray results time to show up
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_inside_q.size() != 0) begin
      report_mismatch($sformatf("%0d answers never arrived", expected_inside_q.size()));
    end
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
